/* rtl/core/hex_token_escape_decoder_top_defines.svh */
// Assertion macros for the escape decoder.
// Used by hex_token_escape_decoder_top.sv; expects clk and rst_n in scope.
`ifndef HEX_TOKEN_ESCAPE_DECODER_TOP_DEFINES_SVH
`define HEX_TOKEN_ESCAPE_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define HTED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HTED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/hted_pkg.sv */
// Shared types, constants and character helpers for the escape decoder.
// No dependencies; used by the front end, queue, back end and top module.
package hted_pkg;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CHAR_LOWER_G    = 8'h67;
    localparam logic [7:0] CHAR_LOWER_D    = 8'h64;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
    localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
    localparam logic [7:0] ALPHA_OFFSET    = 8'h57;   // 'a' - 10

    // match length codes
    localparam logic [2:0] LEN_EMPTY    = 3'd0;
    localparam logic [2:0] LEN_ONE      = 3'd1;
    localparam logic [2:0] LEN_TWO      = 3'd2;
    localparam logic [2:0] LEN_TOKEN    = 3'd5;
    localparam logic [2:0] LEN_HEX_HELD = 3'd6;

    localparam int Q_DEPTH = 2;

    // one job for the back end: a token prefix of length p, then an optional tail
    typedef struct packed {
        logic [2:0] p;
        logic       has_tail;
        logic [7:0] tail_byte;
        logic       tail_err;
        logic       last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] token_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CHAR_UNDERSCORE;
            3'd1:    ch = CHAR_UNDERSCORE;
            3'd2:    ch = CHAR_LOWER_G;
            3'd3:    ch = CHAR_LOWER_D;
            3'd4:    ch = CHAR_LOWER_A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) ||
               ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9));
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        if (c >= CHAR_LOWER_A)
            d = c - ALPHA_OFFSET;
        else
            d = c - CHAR_DIGIT_0;
        return d[3:0];
    endfunction

endpackage

/* rtl/core/hted_if.sv */
// Valid/ready channel interfaces for encoded input and decoded output beats.
// No dependencies.
interface hted_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, in_byte, in_last, input ready);
    modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface hted_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_error;
    logic       out_last;

    modport source (output valid, out_byte, out_error, out_last, input ready);
    modport sink   (input valid, out_byte, out_error, out_last, output ready);
endinterface

/* rtl/core/hted_front.sv */
// Front end: accepts input beats, tracks the token match and emits jobs.
// Depends on hted_pkg and hted_if.
module hted_front (
    input  logic                clk,
    input  logic                rst_n,
    hted_in_if.sink             enc,
    input  hted_pkg::q_status_t q_stat,
    output logic                push,
    output hted_pkg::job_t      push_job
);
    import hted_pkg::*;

    logic [2:0] match_len_reg, match_len_next;
    logic [3:0] hex_hi_reg, hex_hi_next;
    logic       dropping_reg, dropping_next;
    logic       accept;
    logic [7:0] c;
    job_t       j;

    assign enc.ready = !q_stat.full;
    assign accept    = enc.valid && enc.ready;
    assign c         = enc.in_byte;

    always_comb
    begin
        j              = '0;
        j.tail_byte    = c;
        match_len_next = match_len_reg;
        hex_hi_next    = hex_hi_reg;
        dropping_next  = dropping_reg;

        if (dropping_reg)
        begin
            if (enc.in_last)
                dropping_next = 1'b0;
        end
        else if (enc.in_last && (match_len_reg != LEN_HEX_HELD))
        begin
            // flush held prefix literally with the closing byte
            j.p            = match_len_reg;
            j.has_tail     = 1'b1;
            j.last         = 1'b1;
            match_len_next = LEN_EMPTY;
        end
        else if (match_len_reg < LEN_TOKEN)
        begin
            if (c == token_char(match_len_reg))
                match_len_next = match_len_reg + 3'd1;
            else if (c == CHAR_UNDERSCORE)
            begin
                // fall back to the longest held suffix that still starts a token
                if (match_len_reg == LEN_TWO)
                    j.p = LEN_ONE;
                else
                begin
                    j.p            = match_len_reg;
                    match_len_next = LEN_ONE;
                end
            end
            else
            begin
                j.p            = match_len_reg;
                j.has_tail     = 1'b1;
                match_len_next = LEN_EMPTY;
            end
        end
        else if (match_len_reg == LEN_TOKEN)
        begin
            if (is_hex(c))
            begin
                hex_hi_next    = hex_nibble(c);
                match_len_next = LEN_HEX_HELD;
            end
            else
            begin
                j.has_tail     = 1'b1;
                j.tail_byte    = 8'h00;
                j.tail_err     = 1'b1;
                j.last         = 1'b1;
                dropping_next  = 1'b1;
                match_len_next = LEN_EMPTY;
            end
        end
        else
        begin
            match_len_next = LEN_EMPTY;
            j.has_tail     = 1'b1;
            if (is_hex(c))
            begin
                j.tail_byte = {hex_hi_reg, hex_nibble(c)};
                j.last      = enc.in_last;
            end
            else
            begin
                j.tail_byte   = 8'h00;
                j.tail_err    = 1'b1;
                j.last        = 1'b1;
                dropping_next = !enc.in_last;
            end
        end
    end

    assign push     = accept && ((j.p != LEN_EMPTY) || j.has_tail);
    assign push_job = j;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_len_reg <= LEN_EMPTY;
            dropping_reg  <= 1'b0;
        end
        else if (accept)
        begin
            match_len_reg <= match_len_next;
            dropping_reg  <= dropping_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hex_hi_reg <= hex_hi_next;
    end

endmodule

/* rtl/core/hted_queue.sv */
// Short job queue between front and back end.
// Depends on hted_pkg.
module hted_queue #(
    parameter int QDEPTH = hted_pkg::Q_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hted_pkg::job_t      push_job,
    input  logic                pop,
    output hted_pkg::job_t      head,
    output hted_pkg::q_status_t q_stat
);
    import hted_pkg::*;

    localparam int IW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    job_t          mem [QDEPTH];
    logic [IW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    function automatic logic [IW-1:0] bump(input logic [IW-1:0] ptr);
        if (ptr == IW'(QDEPTH - 1))
            return '0;
        return ptr + IW'(1);
    endfunction

    assign head         = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CW'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

/* rtl/core/hted_back.sv */
// Back end: expands each job into result beats through an output register.
// Depends on hted_pkg and hted_if.
module hted_back (
    input  logic                clk,
    input  logic                rst_n,
    input  hted_pkg::job_t      head,
    input  hted_pkg::q_status_t q_stat,
    output logic                pop,
    hted_out_if.source          dec
);
    import hted_pkg::*;

    logic [2:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_error_reg;
    logic       out_last_reg;
    logic       load;
    logic       final_beat;
    logic       in_prefix;
    logic [7:0] beat_byte;
    logic       beat_err;

    assign in_prefix  = (idx_reg < head.p);
    assign final_beat = head.has_tail ? (idx_reg == head.p) : ((idx_reg + 3'd1) == head.p);
    assign beat_byte  = in_prefix ? token_char(idx_reg) : head.tail_byte;
    assign beat_err   = !in_prefix && head.tail_err;
    assign load       = !q_stat.empty && (!out_valid_reg || dec.ready);
    assign pop        = load && final_beat;

    assign dec.valid     = out_valid_reg;
    assign dec.out_byte  = out_byte_reg;
    assign dec.out_error = out_error_reg;
    assign dec.out_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (dec.ready)
                out_valid_reg <= 1'b0;
            // advance through the job, restart on its final beat
            if (load)
                idx_reg <= final_beat ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= beat_byte;
            out_error_reg <= beat_err;
            out_last_reg  <= final_beat && head.last;
        end
    end

endmodule

/* rtl/core/hex_token_escape_decoder_top.sv */
// Path: each job is registered in the job queue, then each result beat in the output register.
// Throughput: one input beat per cycle while the job queue is not full; the back end emits
// one result beat per cycle while the output is not stalled, and one input can release up to six.
// The two-entry job queue sets how long input keeps flowing during such a burst.
// Reset (rst_n low, asynchronous) clears match length, drop flag, queue and output valid.
`include "hex_token_escape_decoder_top_defines.svh"

module hex_token_escape_decoder_top #(
    parameter int QUEUE_DEPTH = hted_pkg::Q_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    hted_in_if.sink    enc,
    hted_out_if.source dec
);
    import hted_pkg::*;

    q_status_t q_stat;
    job_t      push_job;
    job_t      head;
    logic      push;
    logic      pop;

    hted_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .enc      (enc),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    hted_queue #(
        .QDEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    hted_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .dec    (dec)
    );

    `HTED_ASSERT_NOW(a_full_blocks_input, q_stat.full, !enc.ready, "input accepted while job queue full")
    `HTED_ASSERT_NOW(a_error_shape, dec.valid && dec.out_error, dec.out_last && (dec.out_byte == 8'h00), "error beat must be last with zero byte")
    `HTED_ASSERT_NEXT(a_no_phantom_beat, q_stat.empty && !dec.valid, !dec.valid, "result beat without a queued job")

endmodule
